>>> src/box_blur_rgb_clipped_core_assert.svh
// Assertion macros for the box blur core checker.
`ifndef BOX_BLUR_RGB_CLIPPED_CORE_ASSERT_SVH
`define BOX_BLUR_RGB_CLIPPED_CORE_ASSERT_SVH

// same-cycle implication
`define BBRC_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define BBRC_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

>>> src/bbrc_pkg.sv
// ----------------------------------------------------------------------------
// bbrc_pkg
// Shared types and constants of the clipped RGB box blur.
// ----------------------------------------------------------------------------
package bbrc_pkg;

	localparam int PIX_W  = 8;
	localparam int RGB_W  = 3 * PIX_W;
	localparam int KS_W   = 4;
	localparam int IW_W   = 11;
	localparam int IH_W   = 13;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] CFG_KERNEL = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [KS_W-1:0] KERNEL_RST = 4'd3;
	localparam logic [IW_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [IH_W-1:0] HEIGHT_RST = 13'd480;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_TAIL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

endpackage

>>> src/bbrc_ram.sv
// ----------------------------------------------------------------------------
// bbrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbrc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/bbrc_div.sv
// ----------------------------------------------------------------------------
// bbrc_div
// Restoring divider, one quotient bit per cycle, three dividends by one divisor.
// ----------------------------------------------------------------------------
module bbrc_div #(
	parameter int SUM_W = 16,
	parameter int CNT_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0][SUM_W-1:0]         dividend,
	input  logic [CNT_W-1:0]              divisor,
	output logic                          done,
	output logic [2:0][bbrc_pkg::PIX_W-1:0] quotient
);

	import bbrc_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0]      step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [2:0][SUM_W-1:0]  shf_q;
	logic [2:0][CNT_W-1:0]  rem_q;
	logic [2:0][CNT_W:0]    trial;
	logic [2:0]             fit;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], shf_q[c][SUM_W-1]};
			fit[c]   = trial[c] >= {1'b0, divisor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (start) begin
				shf_q[c] <= dividend[c];
				rem_q[c] <= '0;
			end else if (busy_q) begin
				rem_q[c] <= fit[c] ? CNT_W'(trial[c] - {1'b0, divisor}) : CNT_W'(trial[c]);
				shf_q[c] <= {shf_q[c][SUM_W-2:0], fit[c]};
			end
		end
	end

	assign done = done_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quotient[c] = shf_q[c][PIX_W-1:0];
		end
	end

endmodule

>>> src/box_blur_rgb_clipped_core.sv
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped_core: clipped RGB box blur, one item at a time.
// An item causing no result is taken in ST_IDLE; one causing a result runs SETUP,
// READ (over the clipped window area), TAIL, DIV_GO, DIV_WAIT and OUT states.
// Rate is set by the single read port of the line store, one window pixel a cycle.
// Reset restores 3/640/480 and clears counters; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped_core #(
	parameter int MAX_KERNEL = 15,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bbrc_pkg::RGB_W-1:0]    s_tdata,  // blue_in, green_in, red_in
	input  logic                          s_tuser,  // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bbrc_pkg::RGB_W-1:0]    m_tdata,  // blue_out, green_out, red_out
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [bbrc_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [bbrc_pkg::CFG_W-1:0]    cfg_wdata
);

	import bbrc_pkg::*;

	localparam int RMAX  = (MAX_KERNEL - 1) / 2;
	localparam int KMAX  = 2 * RMAX + 1;
	localparam int SLOTS = 2 * RMAX + 2;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WV    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT);
	localparam int HV    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(RMAX + 2);
	localparam int SW    = $clog2(SLOTS);
	localparam int DEPTH = SLOTS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SPW   = $clog2(KMAX + 1);
	localparam int CNT_W = $clog2(KMAX * KMAX + 1);
	localparam int SUM_W = $clog2(255 * KMAX * KMAX + 1);
	localparam int RCW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	state_t state_q, state_d;

	logic [KS_W-1:0] kernel_q;
	logic [IW_W-1:0] width_q;
	logic [IH_W-1:0] height_q;

	logic [WV-1:0]   w_eff;
	logic [HV-1:0]   h_eff;
	logic [RW-1:0]   r_eff;
	logic [2:0]      r_raw;
	logic [RCW-1:0]  delay;

	logic [XW-1:0]   in_col_q;
	logic [HV-1:0]   in_row_q;
	logic [SW-1:0]   in_slot_q;
	logic [RCW-1:0]  recv_q;
	logic [XW-1:0]   ox_q;
	logic [HW-1:0]   oy_q;
	logic [SW-1:0]   oslot_q;

	logic [XW-1:0]   x0_q, x1_q, rx_q;
	logic [HW-1:0]   y1_q, ry_q;
	logic [SW-1:0]   rslot_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0][SUM_W-1:0] sum_q;
	logic            rd_vld_s1;

	logic            accept, complete, emit, wr_en, col_wrap;
	logic [XW-1:0]   col_next;
	logic [HV-1:0]   row_next;
	logic [RCW-1:0]  recv_next;
	logic            restart_cfg, restart_out, out_load, out_last;

	logic [XW-1:0]   x0_c, x1_c;
	logic [HW-1:0]   y0_c, y1_c;
	logic [RW-1:0]   dy_c;
	logic [SW-1:0]   ys_c;
	logic [SPW-1:0]  xs_c, ysp_c;

	logic            rd_en, rd_last, div_start, div_done;
	logic [AW-1:0]   waddr, raddr;
	logic [RGB_W-1:0] rdata;
	logic [2:0][PIX_W-1:0] quot;
	logic            m_tvalid_q;

	// effective configuration
	always_comb begin
		if (width_q == '0) w_eff = WV'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = WV'(MAX_WIDTH);
		else w_eff = WV'(width_q);
		if (height_q == '0) h_eff = HV'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = HV'(MAX_HEIGHT);
		else h_eff = HV'(height_q);
		r_raw = (kernel_q == '0) ? 3'd0 : 3'((kernel_q - 1'b1) >> 1);
		r_eff = (32'(r_raw) > RMAX) ? RW'(RMAX) : RW'(r_raw);
		delay = RCW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
	end

	// input side
	assign accept    = s_tvalid && s_tready;
	assign complete  = 32'(in_row_q) >= 32'(h_eff);
	assign wr_en     = accept && !complete && (s_tuser == CMD_PIXEL);
	assign col_wrap  = 32'(in_col_q) + 1 >= 32'(w_eff);
	assign col_next  = col_wrap ? '0 : XW'(in_col_q + 1'b1);
	assign row_next  = col_wrap ? HV'(in_row_q + 1'b1) : in_row_q;
	assign recv_next = RCW'(recv_q + 1'b1);
	assign emit      = complete ? 1'b1 :
		((s_tuser == CMD_PIXEL) &&
		 ((32'(row_next) >= 32'(h_eff)) || (recv_next > delay)));
	assign waddr     = AW'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));
	assign restart_cfg = cfg_we &&
		(cfg_idx == CFG_KERNEL || cfg_idx == CFG_WIDTH || cfg_idx == CFG_HEIGHT);

	// window bounds of the current output pixel
	always_comb begin
		x0_c = (32'(ox_q) >= 32'(r_eff)) ? XW'(ox_q - r_eff) : '0;
		x1_c = (32'(ox_q) + 32'(r_eff) < 32'(w_eff)) ? XW'(32'(ox_q) + 32'(r_eff)) :
			XW'(w_eff - 1'b1);
		y0_c = (32'(oy_q) >= 32'(r_eff)) ? HW'(oy_q - r_eff) : '0;
		y1_c = (32'(oy_q) + 32'(r_eff) < 32'(h_eff)) ? HW'(32'(oy_q) + 32'(r_eff)) :
			HW'(h_eff - 1'b1);
		dy_c = RW'(oy_q - y0_c);
		ys_c = (32'(oslot_q) >= 32'(dy_c)) ? SW'(oslot_q - dy_c) :
			SW'(32'(oslot_q) + SLOTS - 32'(dy_c));
		xs_c  = SPW'(x1_c - x0_c + 1'b1);
		ysp_c = SPW'(y1_c - y0_c + 1'b1);
	end

	assign rd_last  = (rx_q == x1_q) && (ry_q == y1_q);
	assign raddr    = AW'(32'(rslot_q) * MAX_WIDTH + 32'(rx_q));
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign out_last = (32'(oy_q) + 1 == 32'(h_eff)) && (32'(ox_q) + 1 == 32'(w_eff));
	assign restart_out = out_load && out_last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept && emit) state_d = ST_SETUP;
			ST_SETUP:    state_d = ST_READ;
			ST_READ:     if (rd_last) state_d = ST_TAIL;
			ST_TAIL:     state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_OUT;
			ST_OUT:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_READ:   rd_en     = 1'b1;
			ST_DIV_GO: div_start = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kernel_q   <= KERNEL_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			recv_q     <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			oslot_q    <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_KERNEL: kernel_q <= cfg_wdata[KS_W-1:0];
					CFG_WIDTH:  width_q  <= cfg_wdata[IW_W-1:0];
					CFG_HEIGHT: height_q <= cfg_wdata[IH_W-1:0];
					default:    ;
				endcase
			end
			if (restart_cfg || restart_out) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_slot_q <= '0;
				recv_q    <= '0;
				ox_q      <= '0;
				oy_q      <= '0;
				oslot_q   <= '0;
			end else begin
				if (wr_en) begin
					in_col_q <= col_next;
					in_row_q <= row_next;
					recv_q   <= recv_next;
					if (col_wrap) begin
						in_slot_q <= (32'(in_slot_q) == SLOTS - 1) ? '0 : SW'(in_slot_q + 1'b1);
					end
				end
				if (out_load) begin
					if (32'(ox_q) + 1 == 32'(w_eff)) begin
						ox_q    <= '0;
						oy_q    <= HW'(oy_q + 1'b1);
						oslot_q <= (32'(oslot_q) == SLOTS - 1) ? '0 : SW'(oslot_q + 1'b1);
					end else begin
						ox_q <= XW'(ox_q + 1'b1);
					end
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// window walk and accumulation
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			x0_q    <= x0_c;
			x1_q    <= x1_c;
			y1_q    <= y1_c;
			rx_q    <= x0_c;
			ry_q    <= y0_c;
			rslot_q <= ys_c;
			count_q <= CNT_W'(32'(xs_c) * 32'(ysp_c));
			sum_q   <= '0;
		end else begin
			if (rd_en) begin
				if (rx_q == x1_q) begin
					rx_q    <= x0_q;
					ry_q    <= HW'(ry_q + 1'b1);
					rslot_q <= (32'(rslot_q) == SLOTS - 1) ? '0 : SW'(rslot_q + 1'b1);
				end else begin
					rx_q <= XW'(rx_q + 1'b1);
				end
			end
			if (rd_vld_s1) begin
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= SUM_W'(sum_q[c] + SUM_W'(rdata[c*PIX_W +: PIX_W]));
				end
			end
		end
		if (out_load) begin
			m_tdata <= {quot[2], quot[1], quot[0]};
			m_tlast <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;

	bbrc_ram #(
		.WIDTH (RGB_W),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	bbrc_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot)
	);

endmodule

>>> src/bbrc_checker.sv
// ----------------------------------------------------------------------------
// bbrc_checker
// Port-level checks on the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_rgb_clipped_core_assert.svh"

module bbrc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bbrc_pkg::RGB_W-1:0] m_tdata,
	input logic                       m_tlast
);

	`BBRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output transaction changed")
	`BBRC_ASSERT_NOW(a_load_busy, $rose(m_tvalid), !$past(s_tready), "result loaded while input was open")
	`BBRC_ASSERT_NOW(a_load_idle, $rose(m_tvalid), s_tready, "input not reopened after result load")

endmodule

bind box_blur_rgb_clipped_core bbrc_checker u_bbrc_checker (.*);
